FILE: rtl/mkd_pkg.sv
// Shared definitions for the Morse key decoder: codes, reset values,
// the Morse code table and the types passed between the decoder modules.
// No dependencies.
`default_nettype none

package mkd_pkg;

    localparam int DEF_MAX_SYMBOLS = 8;
    localparam int DEF_TIME_BITS   = 16;

    // Configuration port
    localparam int CFG_W      = 16;
    localparam int CFG_ADDR_W = 2;

    localparam logic [CFG_ADDR_W-1:0] REG_TAP_MODE       = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DOT_DASH_LIMIT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_LETTER_GAP     = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_WORD_GAP       = 2'd3;

    localparam logic             RST_TAP_MODE       = 1'b1;
    localparam logic [CFG_W-1:0] RST_DOT_DASH_LIMIT = 16'd300;
    localparam logic [CFG_W-1:0] RST_LETTER_GAP     = 16'd700;
    localparam logic [CFG_W-1:0] RST_WORD_GAP       = 16'd1400;

    // Input item kinds
    localparam int MODE_W = 2;
    localparam logic [MODE_W-1:0] MODE_TICK     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_KEY_DOWN = 2'd1;
    localparam logic [MODE_W-1:0] MODE_KEY_UP   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_COMMIT   = 2'd3;

    // Stream widths
    localparam int IN_DATA_W  = 8;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 8;

    // Characters
    localparam int CHAR_W = 7;
    localparam logic [CHAR_W-1:0] ASCII_SPACE   = 7'd32;
    localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 7'd65;
    localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 7'd97;
    localparam logic [CHAR_W-1:0] ASCII_ZERO    = 7'd48;

    // Morse table: entries 0..25 are A..Z, 26..35 are 0..9.
    // Symbol i of a code sits at bit i, a dash is 1.
    localparam int NUM_CODES    = 36;
    localparam int NUM_LETTERS  = 26;
    localparam int CODE_MAX_LEN = 5;
    localparam int CODE_LEN_W   = 3;
    localparam int CODE_IDX_W   = 6;

    localparam logic [CODE_LEN_W-1:0] CODE_LEN [NUM_CODES] = '{
        3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4,
        3'd3, 3'd4, 3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1,
        3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4,
        3'd5, 3'd5, 3'd5, 3'd5, 3'd5,
        3'd5, 3'd5, 3'd5, 3'd5, 3'd5
    };

    localparam logic [CODE_MAX_LEN-1:0] CODE_BITS [NUM_CODES] = '{
        5'b00010, 5'b00001, 5'b00101, 5'b00001, 5'b00000,
        5'b00100, 5'b00011, 5'b00000, 5'b00000, 5'b01110,
        5'b00101, 5'b00010, 5'b00011, 5'b00001, 5'b00111,
        5'b00110, 5'b01011, 5'b00010, 5'b00000, 5'b00001,
        5'b00100, 5'b01000, 5'b00110, 5'b01001, 5'b01101,
        5'b00011,
        5'b11111, 5'b11110, 5'b11100, 5'b11000, 5'b10000,
        5'b00000, 5'b00001, 5'b00011, 5'b00111, 5'b01111
    };

    // Output queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;
    localparam int PUSH_N_W   = 2;

    typedef struct packed {
        logic              hit;
        logic [CODE_IDX_W-1:0] index;
    } lookup_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last;
    } result_t;

    typedef struct packed {
        logic [PUSH_N_W-1:0] n;
        result_t             r0;
        result_t             r1;
    } push_t;

    typedef struct packed {
        logic [FIFO_CNT_W-1:0] count;
    } fifo_stat_t;

endpackage

`default_nettype wire

FILE: rtl/mkd_lookup.sv
// Morse table lookup: matches the symbol buffer against all table entries.
// Depends on mkd_pkg.
`default_nettype none

module mkd_lookup #(
    parameter int MAX_SYMBOLS = mkd_pkg::DEF_MAX_SYMBOLS,
    localparam int CNT_W = $clog2(MAX_SYMBOLS + 1)
) (
    input  wire logic [MAX_SYMBOLS-1:0] symbol_bits,
    input  wire logic [CNT_W-1:0]       symbol_count,
    input  wire logic                   overflow,
    output mkd_pkg::lookup_t            result
);
    import mkd_pkg::*;

    // Bits above the symbol count are always zero, so the low bits and the
    // count together identify the code.
    always_comb
    begin
        result = '0;
        for (int e = 0; e < NUM_CODES; e++)
        begin
            if (!overflow && !result.hit
                && symbol_count == CNT_W'(CODE_LEN[e])
                && symbol_bits[CODE_MAX_LEN-1:0] == CODE_BITS[e])
            begin
                result.hit   = 1'b1;
                result.index = CODE_IDX_W'(e);
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/mkd_out_fifo.sv
// Four-entry result queue: takes up to two results per cycle, hands out one
// per transfer on the master stream. Depends on mkd_pkg.
`default_nettype none

module mkd_out_fifo (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire mkd_pkg::push_t                  push,
    output mkd_pkg::fifo_stat_t                  stat,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [mkd_pkg::OUT_DATA_W-1:0]       m_tdata,  // [6:0] char_code
    output logic                                 m_tlast   // last
);
    import mkd_pkg::*;

    result_t               mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;
    logic                  pop;
    result_t               head;

    assign pop      = (count_reg != '0) && m_tready;
    assign head     = mem[rd_ptr_reg];
    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = OUT_DATA_W'(head.char_code);
    assign m_tlast  = head.last;
    assign stat.count = count_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(push.n);
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(pop);
        count_next  = count_reg + FIFO_CNT_W'(push.n) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.n != '0)
        begin
            mem[wr_ptr_reg] <= push.r0;
        end
        if (push.n == PUSH_N_W'(2))
        begin
            mem[wr_ptr_reg + FIFO_PTR_W'(1)] <= push.r1;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/morse_key_decoder_core.sv
// Top level of the two-key Morse decoder: state update, configuration
// registers and result generation. Depends on mkd_pkg, mkd_lookup, mkd_out_fifo.
//
// Usage. Each transfer on the slave stream is one event: s_tdata[1:0] gives
// its kind (millisecond tick, key down, key up, commit-key release) and
// s_tuser carries the key select and the upper-case flag. Decoded characters
// leave on the master stream as ASCII in m_tdata[6:0]; m_tlast marks the final
// character produced by one event (a word gap yields a letter, if it decodes, and a space).
// Configuration is written through cfg_we/cfg_addr/cfg_wdata while the block
// is idle; a write takes effect at the next clock edge.
// A character enters the output queue at the clock edge that takes its event.
// Throughput: one event per cycle while s_tready is high. The event updates all
// state in the cycle it is accepted and pushes up to two characters into a
// four-entry output queue; s_tready is high while that queue has room for two
// more entries, so an event is still taken while one character waits for the
// receiver. When the receiver stalls the queue fills and s_tready falls;
// nothing is lost. Reset clears the symbol buffer, the timers and the queue,
// and loads the configuration defaults (tap mode on, 300 ms, 700 ms, 1400 ms).
`default_nettype none

module morse_key_decoder_core #(
    parameter int MAX_SYMBOLS = mkd_pkg::DEF_MAX_SYMBOLS,
    parameter int TIME_BITS   = mkd_pkg::DEF_TIME_BITS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // Slave stream
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [mkd_pkg::IN_DATA_W-1:0] s_tdata,   // [1:0] mode
    input  wire logic [mkd_pkg::IN_USER_W-1:0] s_tuser,   // [0] key_sel, [1] uppercase
    // Master stream
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [mkd_pkg::OUT_DATA_W-1:0]     m_tdata,   // [6:0] char_code
    output logic                               m_tlast,   // last
    // Configuration write port
    input  wire logic                          cfg_we,
    input  wire logic [mkd_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [mkd_pkg::CFG_W-1:0]     cfg_wdata
);
    import mkd_pkg::*;

    localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);
    localparam int CMP_W = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;

    // Configuration registers
    logic             tap_mode_reg;
    logic [CFG_W-1:0] dot_dash_limit_reg;
    logic [CFG_W-1:0] letter_gap_reg;
    logic [CFG_W-1:0] word_gap_reg;

    // Decoder state
    logic [MAX_SYMBOLS-1:0] symbol_bits_reg, symbol_bits_next;
    logic [CNT_W-1:0]       symbol_count_reg, symbol_count_next;
    logic                   overflow_reg, overflow_next;
    logic [TIME_BITS-1:0]   idle_ms_reg, idle_ms_next;
    logic                   idle_active_reg, idle_active_next;
    logic [TIME_BITS-1:0]   held_ms_reg [2];
    logic [TIME_BITS-1:0]   held_ms_next [2];
    logic [1:0]             held_valid_reg, held_valid_next;

    // Event fields
    logic              accept;
    logic [MODE_W-1:0] in_mode;
    logic              in_key;
    logic              in_upper;

    // Working signals
    lookup_t              lookup;
    fifo_stat_t           fifo_stat;
    push_t                push;
    logic [CHAR_W-1:0]    hit_char;
    logic                 nonempty;
    logic [TIME_BITS-1:0] idle_inc;
    logic                 dash;

    assign accept   = s_tvalid && s_tready;
    assign in_mode  = s_tdata[MODE_W-1:0];
    assign in_key   = s_tuser[0];
    assign in_upper = s_tuser[1];
    assign s_tready = fifo_stat.count <= FIFO_CNT_W'(FIFO_DEPTH - 2);
    assign nonempty = (symbol_count_reg != '0) || overflow_reg;

    mkd_lookup #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_lookup (
        .symbol_bits  (symbol_bits_reg),
        .symbol_count (symbol_count_reg),
        .overflow     (overflow_reg),
        .result       (lookup)
    );

    // Table index to ASCII; letters follow the case flag, digits do not.
    always_comb
    begin
        if (lookup.index < CODE_IDX_W'(NUM_LETTERS))
        begin
            hit_char = (in_upper ? ASCII_UPPER_A : ASCII_LOWER_A)
                       + CHAR_W'(lookup.index);
        end
        else
        begin
            hit_char = ASCII_ZERO + CHAR_W'(lookup.index) - CHAR_W'(NUM_LETTERS);
        end
    end

    // Idle time saturates, so a gap beyond the counter range never fires.
    assign idle_inc = (idle_ms_reg != '1) ? idle_ms_reg + TIME_BITS'(1) : idle_ms_reg;

    // Symbol picked by a key release: in tap mode the key itself, otherwise
    // the recorded hold time; a release with no recorded press is a dot.
    always_comb
    begin
        if (tap_mode_reg)
        begin
            dash = in_key;
        end
        else if (held_valid_reg[in_key])
        begin
            dash = CMP_W'(held_ms_reg[in_key]) >= CMP_W'(dot_dash_limit_reg);
        end
        else
        begin
            dash = 1'b0;
        end
    end

    always_comb
    begin
        symbol_bits_next  = symbol_bits_reg;
        symbol_count_next = symbol_count_reg;
        overflow_next     = overflow_reg;
        idle_ms_next      = idle_ms_reg;
        idle_active_next  = idle_active_reg;
        held_ms_next      = held_ms_reg;
        held_valid_next   = held_valid_reg;
        push              = '0;

        if (accept)
        begin
            case (in_mode)
                MODE_TICK:
                begin
                    for (int k = 0; k < 2; k++)
                    begin
                        if (held_valid_reg[k] && held_ms_reg[k] != '1)
                        begin
                            held_ms_next[k] = held_ms_reg[k] + TIME_BITS'(1);
                        end
                    end
                    if (idle_active_reg)
                    begin
                        idle_ms_next = idle_inc;
                        if (nonempty)
                        begin
                            if (CMP_W'(idle_inc) >= CMP_W'(word_gap_reg))
                            begin
                                // Word gap: letter (if it decodes) then a space.
                                symbol_bits_next  = '0;
                                symbol_count_next = '0;
                                overflow_next     = 1'b0;
                                idle_active_next  = 1'b0;
                                if (lookup.hit)
                                begin
                                    push.n  = PUSH_N_W'(2);
                                    push.r0 = '{char_code: hit_char, last: 1'b0};
                                    push.r1 = '{char_code: ASCII_SPACE, last: 1'b1};
                                end
                                else
                                begin
                                    push.n  = PUSH_N_W'(1);
                                    push.r0 = '{char_code: ASCII_SPACE, last: 1'b1};
                                end
                            end
                            else if (CMP_W'(idle_inc) >= CMP_W'(letter_gap_reg))
                            begin
                                symbol_bits_next  = '0;
                                symbol_count_next = '0;
                                overflow_next     = 1'b0;
                                idle_active_next  = 1'b0;
                                if (lookup.hit)
                                begin
                                    push.n  = PUSH_N_W'(1);
                                    push.r0 = '{char_code: hit_char, last: 1'b1};
                                end
                            end
                        end
                    end
                end
                MODE_KEY_DOWN:
                begin
                    if (!tap_mode_reg)
                    begin
                        held_ms_next[in_key]    = '0;
                        held_valid_next[in_key] = 1'b1;
                    end
                end
                MODE_KEY_UP:
                begin
                    if (!tap_mode_reg)
                    begin
                        held_ms_next[in_key]    = '0;
                        held_valid_next[in_key] = 1'b0;
                    end
                    if (symbol_count_reg < CNT_W'(MAX_SYMBOLS))
                    begin
                        symbol_bits_next  = symbol_bits_reg
                                            | (MAX_SYMBOLS'(dash) << symbol_count_reg);
                        symbol_count_next = symbol_count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        overflow_next = 1'b1;
                    end
                    idle_ms_next     = '0;
                    idle_active_next = 1'b1;
                end
                MODE_COMMIT:
                begin
                    // The commit key leaves the idle timer running.
                    if (nonempty)
                    begin
                        symbol_bits_next  = '0;
                        symbol_count_next = '0;
                        overflow_next     = 1'b0;
                        if (lookup.hit)
                        begin
                            push.n  = PUSH_N_W'(1);
                            push.r0 = '{char_code: hit_char, last: 1'b1};
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            symbol_bits_reg  <= '0;
            symbol_count_reg <= '0;
            overflow_reg     <= 1'b0;
            idle_ms_reg      <= '0;
            idle_active_reg  <= 1'b0;
            held_ms_reg[0]   <= '0;
            held_ms_reg[1]   <= '0;
            held_valid_reg   <= '0;
        end
        else
        begin
            symbol_bits_reg  <= symbol_bits_next;
            symbol_count_reg <= symbol_count_next;
            overflow_reg     <= overflow_next;
            idle_ms_reg      <= idle_ms_next;
            idle_active_reg  <= idle_active_next;
            held_ms_reg[0]   <= held_ms_next[0];
            held_ms_reg[1]   <= held_ms_next[1];
            held_valid_reg   <= held_valid_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_mode_reg       <= RST_TAP_MODE;
            dot_dash_limit_reg <= RST_DOT_DASH_LIMIT;
            letter_gap_reg     <= RST_LETTER_GAP;
            word_gap_reg       <= RST_WORD_GAP;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_TAP_MODE:       tap_mode_reg       <= cfg_wdata[0];
                REG_DOT_DASH_LIMIT: dot_dash_limit_reg <= cfg_wdata;
                REG_LETTER_GAP:     letter_gap_reg     <= cfg_wdata;
                REG_WORD_GAP:       word_gap_reg       <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    mkd_out_fifo u_out_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .stat     (fifo_stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // An overflowed buffer is always a full one.
    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        overflow_reg |-> symbol_count_reg == CNT_W'(MAX_SYMBOLS))
        else $error("overflow flag set with a buffer that is not full");

    // A commit-key release always leaves the buffer empty.
    a_commit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_mode == MODE_COMMIT) |=> (symbol_count_reg == '0 && !overflow_reg))
        else $error("symbol buffer not cleared after commit");

    // The output queue never holds more than its depth.
    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_stat.count <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("output queue overrun");

endmodule

`default_nettype wire

FILE: test/tb_top.sv
// Self-checking testbench for morse_key_decoder_core: streams key events and
// millisecond ticks into the decoder and checks every decoded character against
// its own model of the symbol buffer and the gap timers. Depends on mkd_pkg and morse_key_decoder_core.

module tb_top;

    import mkd_pkg::*;

    localparam int SYMS_MAX = DEF_MAX_SYMBOLS;
    localparam int TIME_W   = DEF_TIME_BITS;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              key;
        logic              upper;
    } stroke_t;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } decoded_t;

    // Morse codes written out, A to Z then 0 to 9.
    string morse_tab [NUM_CODES] = '{
        ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
        "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
        "..-", "...-", ".--", "-..-", "-.--", "--..",
        "-----", ".----", "..---", "...--", "....-",
        ".....", "-....", "--...", "---..", "----."
    };

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [IN_USER_W-1:0]  s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_W-1:0]      cfg_wdata = '0;

    morse_key_decoder_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    stroke_t  strokes_pending [$];
    decoded_t chars_due [$];
    stroke_t  next_stroke;
    logic     taken = 1'b0;
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;
    int       fail_count = 0;
    int       strokes_taken = 0;
    int       chars_checked = 0;
    int       strokes_queued = 0;
    int       settings_used = 0;

    // Decoder copy: configuration as last written, and the decoding state.
    logic              mdl_tap = RST_TAP_MODE;
    logic [CFG_W-1:0]  mdl_dash_limit = RST_DOT_DASH_LIMIT;
    logic [CFG_W-1:0]  mdl_letter_gap = RST_LETTER_GAP;
    logic [CFG_W-1:0]  mdl_word_gap = RST_WORD_GAP;
    logic [SYMS_MAX-1:0] sym_bits = '0;
    int                sym_count = 0;
    logic              sym_overflow = 1'b0;
    logic [TIME_W-1:0] idle_ms = '0;
    logic              idle_on = 1'b0;
    logic [TIME_W-1:0] held_ms [2] = '{'0, '0};
    logic              held_ok [2] = '{1'b0, 1'b0};

    // Values the stimulus currently assumes, used to shape the sequences.
    logic              stim_tap = RST_TAP_MODE;
    int                stim_dash_limit = RST_DOT_DASH_LIMIT;
    int                stim_letter_gap = RST_LETTER_GAP;
    int                stim_word_gap = RST_WORD_GAP;

    task automatic note_mismatch(input string what);
        fail_count++;
        if (fail_count <= 10)
            $display("mismatch: %s", what);
    endtask

    function automatic logic rand_bit();
        return 1'($urandom_range(1));
    endfunction

    // Index of the code that matches the buffer, or -1.
    function automatic int match_code();
        int  e;
        int  i;
        bit  same;
        if (sym_overflow)
            return -1;
        for (e = 0; e < NUM_CODES; e++) begin
            if (morse_tab[e].len() == sym_count) begin
                same = 1'b1;
                for (i = 0; i < sym_count; i++)
                    if ((morse_tab[e][i] == "-") != sym_bits[i])
                        same = 1'b0;
                if (same)
                    return e;
            end
        end
        return -1;
    endfunction

    // Looks the buffer up and clears it; returns the ASCII code or -1.
    function automatic int flush_letter(input logic upper);
        int e;
        if (sym_count == 0 && !sym_overflow)
            return -1;
        e = match_code();
        sym_bits = '0;
        sym_count = 0;
        sym_overflow = 1'b0;
        if (e < 0)
            return -1;
        if (e < NUM_LETTERS)
            return (upper ? ASCII_UPPER_A : ASCII_LOWER_A) + e;
        return ASCII_ZERO + (e - NUM_LETTERS);
    endfunction

    function automatic void add_symbol(input logic dash);
        if (sym_count < SYMS_MAX) begin
            sym_bits[sym_count] = dash;
            sym_count++;
        end else begin
            sym_overflow = 1'b1;
        end
        idle_ms = '0;
        idle_on = 1'b1;
    endfunction

    // Applies one accepted stroke and queues the characters it must produce.
    function automatic void decode_stroke(input stroke_t st);
        logic [CHAR_W-1:0] outc [2];
        int                n;
        int                c;
        int                k;
        logic              dash;
        decoded_t          item;
        n = 0;
        case (st.mode)
            MODE_TICK: begin
                for (k = 0; k < 2; k++)
                    if (held_ok[k] && held_ms[k] != '1)
                        held_ms[k]++;
                if (idle_on) begin
                    if (idle_ms != '1)
                        idle_ms++;
                    if (sym_count != 0 || sym_overflow) begin
                        if (idle_ms >= mdl_word_gap) begin
                            c = flush_letter(st.upper);
                            if (c >= 0) begin
                                outc[n] = c[CHAR_W-1:0];
                                n++;
                            end
                            outc[n] = ASCII_SPACE;
                            n++;
                            idle_on = 1'b0;
                        end else if (idle_ms >= mdl_letter_gap) begin
                            c = flush_letter(st.upper);
                            if (c >= 0) begin
                                outc[n] = c[CHAR_W-1:0];
                                n++;
                            end
                            idle_on = 1'b0;
                        end
                    end
                end
            end
            MODE_KEY_DOWN: begin
                if (!mdl_tap) begin
                    held_ms[st.key] = '0;
                    held_ok[st.key] = 1'b1;
                end
            end
            MODE_KEY_UP: begin
                if (mdl_tap) begin
                    dash = st.key;
                end else if (held_ok[st.key]) begin
                    dash = (held_ms[st.key] >= mdl_dash_limit);
                    held_ok[st.key] = 1'b0;
                    held_ms[st.key] = '0;
                end else begin
                    // A release with no press on record counts as a dot.
                    dash = 1'b0;
                end
                add_symbol(dash);
            end
            default: begin
                c = flush_letter(st.upper);
                if (c >= 0) begin
                    outc[n] = c[CHAR_W-1:0];
                    n++;
                end
            end
        endcase
        for (k = 0; k < n; k++) begin
            item.code = outc[k];
            item.last = (k == n - 1);
            chars_due.insert(chars_due.size(), item);
        end
    endfunction

    // Driver: a new stroke is offered once the previous transfer has happened.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_tvalid || taken)
            begin
                if (strokes_pending.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_stroke = strokes_pending.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {{(IN_DATA_W-MODE_W){1'b0}}, next_stroke.mode};
                    s_tuser  <= {next_stroke.upper, next_stroke.key};
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: checks output transfers, then predicts from input transfers and tracks configuration writes.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (chars_due.size() == 0)
                begin
                    note_mismatch($sformatf("unexpected character data=%0h last=%0b",
                                            m_tdata, m_tlast));
                end
                else
                begin
                    decoded_t want;
                    want = chars_due.pop_front();
                    if (m_tdata !== {{(OUT_DATA_W-CHAR_W){1'b0}}, want.code} ||
                        m_tlast !== want.last)
                        note_mismatch($sformatf(
                            "character %0d: expected data=%0h last=%0b, got data=%0h last=%0b",
                            chars_checked, want.code, want.last, m_tdata, m_tlast));
                    chars_checked++;
                end
            end
            if (s_tvalid && s_tready)
            begin
                decode_stroke('{mode: s_tdata[MODE_W-1:0], key: s_tuser[0],
                                upper: s_tuser[1]});
                strokes_taken++;
            end
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_TAP_MODE:       mdl_tap = cfg_wdata[0];
                    REG_DOT_DASH_LIMIT: mdl_dash_limit = cfg_wdata;
                    REG_LETTER_GAP:     mdl_letter_gap = cfg_wdata;
                    default:            mdl_word_gap = cfg_wdata;
                endcase
            end
        end
        taken <= rst_n && s_tvalid && s_tready;
    end

    task automatic add_stroke(input logic [MODE_W-1:0] mode, input logic key,
                              input logic upper);
        stroke_t st;
        st.mode  = mode;
        st.key   = key;
        st.upper = upper;
        strokes_pending.insert(strokes_pending.size(), st);
        strokes_queued++;
    endtask

    task automatic add_ticks(input int count);
        repeat (count)
            add_stroke(MODE_TICK, rand_bit(), rand_bit());
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Waits until every stroke is taken and every character has arrived, with a
    // cap once the input side is empty, then lets the state update settle.
    task automatic settle();
        int spare;
        spare = 0;
        while ((strokes_pending.size() != 0 || s_tvalid || chars_due.size() != 0)
               && spare < 2000)
        begin
            @(negedge clk);
            if (strokes_pending.size() == 0 && !s_tvalid)
                spare++;
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic apply_setting(input int sel);
        logic             t;
        logic [CFG_W-1:0] d;
        logic [CFG_W-1:0] l;
        logic [CFG_W-1:0] w;
        logic [CFG_W-2:0] junk;
        case (sel)
            0: begin t = 1'b1; d = 3; l = 4; w = 9; end
            1: begin
                t = 1'b0;
                d = CFG_W'($urandom_range(1, 6));
                l = CFG_W'($urandom_range(3, 10));
                w = CFG_W'($urandom_range(3, 16));
            end
            2: begin t = 1'b0; d = 0; l = 0; w = 0; end
            3: begin t = 1'b0; d = 16'hFFFF; l = 2; w = 16'hFFFF; end
            default: begin
                t = 1'b1;
                d = CFG_W'($urandom_range(16'hFFFF));
                l = 16'hFFFF;
                w = 3;
            end
        endcase
        // Only bit 0 of the tap mode register is meaningful.
        junk = (CFG_W-1)'($urandom);
        write_reg(REG_TAP_MODE, {junk, t});
        write_reg(REG_DOT_DASH_LIMIT, d);
        write_reg(REG_LETTER_GAP, l);
        write_reg(REG_WORD_GAP, w);
        stim_tap = t;
        stim_dash_limit = d;
        stim_letter_gap = l;
        stim_word_gap = w;
        settings_used++;
    endtask

    // One letter: a run of symbols, then a commit key or an idle stretch.
    task automatic queue_letter();
        int   n;
        int   hold_span;
        int   gap;
        logic k;
        n = ($urandom_range(9) == 0) ? $urandom_range(6, 10) : $urandom_range(1, 5);
        hold_span = (stim_dash_limit > 8) ? 6 : 2 * stim_dash_limit + 1;
        if (stim_word_gap < 24)
            gap = stim_word_gap;
        else
            gap = (stim_letter_gap < 24) ? stim_letter_gap : 20;
        repeat (n)
        begin
            k = rand_bit();
            if (stim_tap)
            begin
                if ($urandom_range(9) == 0)
                    add_stroke(MODE_KEY_DOWN, k, rand_bit());
            end
            else if ($urandom_range(9) != 0)
            begin
                add_stroke(MODE_KEY_DOWN, k, rand_bit());
                add_ticks($urandom_range(hold_span));
            end
            add_stroke(MODE_KEY_UP, k, rand_bit());
        end
        if ($urandom_range(99) < 40)
            add_stroke(MODE_COMMIT, rand_bit(), rand_bit());
        else
            add_ticks($urandom_range(gap + 3));
    endtask

    task automatic queue_block(input int n_strokes);
        int start;
        start = strokes_queued;
        while (strokes_queued - start < n_strokes)
        begin
            if ($urandom_range(99) < 15)
                add_stroke(MODE_W'($urandom_range(3)), rand_bit(), rand_bit());
            else
                queue_letter();
        end
    endtask

    initial
    begin
        int ph;
        int c;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part under the reset configuration (tap mode).
        add_stroke(MODE_COMMIT, 1'b0, 1'b1);     // commit with an empty buffer
        add_stroke(MODE_KEY_DOWN, 1'b1, 1'b0);   // ignored in tap mode
        add_stroke(MODE_TICK, 1'b0, 1'b0);
        add_stroke(MODE_KEY_UP, 1'b0, 1'b1);
        add_stroke(MODE_KEY_UP, 1'b1, 1'b0);
        add_stroke(MODE_COMMIT, 1'b0, 1'b1);     // upper-case A
        repeat (4) add_stroke(MODE_KEY_UP, 1'b1, 1'b1);
        add_stroke(MODE_COMMIT, 1'b1, 1'b0);     // four dashes match nothing
        repeat (9) add_stroke(MODE_KEY_UP, 1'b0, 1'b0);
        add_stroke(MODE_COMMIT, 1'b0, 1'b1);     // overflowed buffer matches nothing

        // Random letters under several register settings and pacing modes.
        for (ph = 0; ph < 4; ph++)
        begin
            for (c = 0; c < 5; c++)
            begin
                settle();
                case (ph)
                    0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                    1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
                    2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
                    default: begin send_idle_pct = 29; recv_stall_pct = 29; end
                endcase
                apply_setting(c);
                queue_block(35);
            end
        end

        settle();
        repeat (10) @(negedge clk);
        if (chars_due.size() != 0)
            note_mismatch($sformatf("%0d characters never arrived", chars_due.size()));
        $display("covered %0d strokes over %0d register settings and four pacing modes",
                 strokes_taken, settings_used);
        $display("%0d decoded characters compared, %0d mismatches", chars_checked,
                 fail_count);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("timeout with %0d strokes queued and %0d characters due",
                 strokes_pending.size(), chars_due.size());
        $display("status: fail");
        $finish;
    end

endmodule
